// ===== src/dse_pkg.sv =====
// dse_pkg: shared constants, control-word types and the microprogram ROM
// for the disjoint-set engine. No dependencies; all but dse_ram use it.
package dse_pkg;

   // forest size and field widths
   localparam int NODES     = 1024;
   localparam int IDX_W     = 10;
   localparam int COUNT_W   = 11;
   localparam int RANK_W    = 4;
   localparam logic [RANK_W-1:0]  RANK_MAX  = 4'd15;
   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NODES - 1);
   localparam logic [COUNT_W-1:0] NODES_CNT = COUNT_W'(NODES);

   // request operation codes (the spare code acts as find)
   localparam logic [1:0] OP_FIND      = 2'd0;
   localparam logic [1:0] OP_UNION     = 2'd1;
   localparam logic [1:0] OP_CONNECTED = 2'd2;

   // response status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_INDEX = 1'b1;

   // microprogram step addresses
   typedef enum logic [4:0] {
      ST_IDLE    = 5'd0,
      ST_START   = 5'd1,
      ST_WALK    = 5'd2,
      ST_HALVE   = 5'd3,
      ST_FOUND   = 5'd4,
      ST_FOUND_A = 5'd5,
      ST_RESTART = 5'd6,
      ST_FOUND_B = 5'd7,
      ST_RANK_A  = 5'd8,
      ST_RANK_B  = 5'd9,
      ST_LINK    = 5'd10,
      ST_LINK_GE = 5'd11,
      ST_LINK_LT = 5'd12,
      ST_SAME    = 5'd13,
      ST_ERR     = 5'd14,
      ST_FINISH  = 5'd15,
      ST_EMIT    = 5'd16
   } step_type;

   // jump conditions
   typedef enum logic [3:0] {
      C_NEVER  = 4'd0,
      C_ALWAYS = 4'd1,
      C_NO_REQ = 4'd2,
      C_BAD    = 4'd3,
      C_ROOT   = 4'd4,
      C_SECOND = 4'd5,
      C_FIND   = 4'd6,
      C_SAME   = 4'd7,
      C_CONN   = 4'd8,
      C_LT     = 4'd9,
      C_BUSY   = 4'd10
   } cond_type;

   // parent table read address source
   typedef enum logic [1:0] {
      PR_X  = 2'd0,
      PR_A  = 2'd1,
      PR_P  = 2'd2,
      PR_RD = 2'd3
   } prd_sel_type;

   // rank table read address source
   typedef enum logic {
      KR_RA = 1'b0,
      KR_X  = 1'b1
   } krd_sel_type;

   // walk pointer load
   typedef enum logic [1:0] {
      XL_HOLD = 2'd0,
      XL_A    = 2'd1,
      XL_B    = 2'd2,
      XL_P    = 2'd3
   } xld_type;

   // parent table write
   typedef enum logic [1:0] {
      PW_NONE  = 2'd0,
      PW_HALVE = 2'd1,
      PW_GE    = 2'd2,
      PW_LT    = 2'd3
   } pwr_type;

   typedef struct packed {
      prd_sel_type prd_sel;
      krd_sel_type krd_sel;
      xld_type     xld;
      logic        ld_p;
      logic        ld_ra;
      logic        ld_root;
      logic        ld_ka;
      logic        ld_kb;
      logic        set_phase;
      logic        set_same;
      logic        set_err;
      pwr_type     pwr;
      logic        rank_bump;
      logic        merge;
      logic        emit;
      cond_type    cond;
      step_type    target;
   } ctrl_type;

   // microprogram: one control word per step
   function automatic ctrl_type uc_rom(input step_type step);
      ctrl_type c;
      c = '0;
      unique case (step)
         ST_IDLE: begin
            c.cond = C_NO_REQ; c.target = ST_IDLE;
         end
         ST_START: begin
            c.prd_sel = PR_A; c.xld = XL_A; c.cond = C_BAD; c.target = ST_ERR;
         end
         ST_WALK: begin
            c.prd_sel = PR_RD; c.ld_p = 1'b1; c.cond = C_ROOT; c.target = ST_FOUND;
         end
         ST_HALVE: begin
            c.prd_sel = PR_P; c.xld = XL_P; c.pwr = PW_HALVE;
            c.cond = C_ALWAYS; c.target = ST_WALK;
         end
         ST_FOUND: begin
            c.cond = C_SECOND; c.target = ST_FOUND_B;
         end
         ST_FOUND_A: begin
            c.ld_ra = 1'b1; c.ld_root = 1'b1; c.xld = XL_B; c.set_phase = 1'b1;
            c.cond = C_FIND; c.target = ST_FINISH;
         end
         ST_RESTART: begin
            c.prd_sel = PR_X; c.cond = C_ALWAYS; c.target = ST_WALK;
         end
         ST_FOUND_B: begin
            c.krd_sel = KR_RA; c.cond = C_SAME; c.target = ST_SAME;
         end
         ST_RANK_A: begin
            c.ld_ka = 1'b1; c.krd_sel = KR_X; c.cond = C_CONN; c.target = ST_FINISH;
         end
         ST_RANK_B: begin
            c.ld_kb = 1'b1;
         end
         ST_LINK: begin
            c.cond = C_LT; c.target = ST_LINK_LT;
         end
         ST_LINK_GE: begin
            c.pwr = PW_GE; c.rank_bump = 1'b1; c.merge = 1'b1;
            c.cond = C_ALWAYS; c.target = ST_FINISH;
         end
         ST_LINK_LT: begin
            c.pwr = PW_LT; c.ld_root = 1'b1; c.merge = 1'b1;
            c.cond = C_ALWAYS; c.target = ST_FINISH;
         end
         ST_SAME: begin
            c.set_same = 1'b1; c.cond = C_ALWAYS; c.target = ST_FINISH;
         end
         ST_ERR: begin
            c.set_err = 1'b1;
         end
         ST_FINISH: begin
            c.cond = C_BUSY; c.target = ST_FINISH;
         end
         ST_EMIT: begin
            c.emit = 1'b1; c.cond = C_ALWAYS; c.target = ST_IDLE;
         end
         default: begin
            c.cond = C_ALWAYS; c.target = ST_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== src/dse_req_if.sv =====
// dse_req_if: request channel (valid/ready plus operation and indices).
// Depends on dse_pkg for the index width.
interface dse_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                operation;
   logic [dse_pkg::IDX_W-1:0] first_index;
   logic [dse_pkg::IDX_W-1:0] second_index;

   modport source (output valid, operation, first_index, second_index, input ready);
   modport sink   (input valid, operation, first_index, second_index, output ready);
endinterface

// ===== src/dse_rsp_if.sv =====
// dse_rsp_if: response channel (valid/ready plus result fields).
// Depends on dse_pkg for field widths.
interface dse_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        status;
   logic [dse_pkg::IDX_W-1:0]   root;
   logic                        same_set;
   logic                        merged;
   logic [dse_pkg::COUNT_W-1:0] live_sets;

   modport source (output valid, status, root, same_set, merged, live_sets, input ready);
   modport sink   (input valid, status, root, same_set, merged, live_sets, output ready);
endinterface

// ===== src/disjoint_set_engine.sv =====
// disjoint_set_engine: union-find engine top level (microcoded sequencer).
// Depends on dse_pkg, dse_req_if, dse_rsp_if and dse_ram.

// Union-find over up to 1024 elements, union by rank and path splitting.
// A request beat carries operation (0 find, 1 union, 2 connected, 3 acts as
// find) and two element indices; each request returns exactly one response
// beat with status, root, same_set, merged and the live set count. Requests
// are handled one at a time. Each parent hop passes through the WALK and
// HALVE steps and uses the parent table's single read port, whose data
// comes back in the cycle after the address. A response may sit waiting
// for ready; the engine stalls only when it must present the next one.
// Writing csr_write_data with csr_write_enable sets the element count
// (0 is taken as 1, values above 1024 as 1024) and starts a clearing pass
// that rewrites the whole parent and rank tables; the same pass runs after
// reset. req_if.ready stays low during it.
module disjoint_set_engine (
   input  logic                         clock,
   input  logic                         reset,
   dse_req_if.sink                      req_if,
   dse_rsp_if.source                    rsp_if,
   input  logic                         csr_write_enable,
   input  logic [dse_pkg::COUNT_W-1:0]  csr_write_data
);

   localparam int IW = dse_pkg::IDX_W;
   localparam int CW = dse_pkg::COUNT_W;
   localparam int RW = dse_pkg::RANK_W;

   // ---- sequencer state ----
   dse_pkg::step_type upc_ff, upc_in;
   dse_pkg::ctrl_type ctrl;
   logic              cond_true;

   // ---- clearing pass ----
   logic          clr_busy_ff, clr_busy_in;
   logic [IW-1:0] clr_idx_ff, clr_idx_in;

   // ---- configuration and set count ----
   logic [CW-1:0] ecount_ff, ecount_in;
   logic [CW-1:0] sets_ff, sets_in;
   logic [CW-1:0] csr_clamped;

   // ---- request latch and datapath registers ----
   logic [1:0]    op_ff, op_in;
   logic [IW-1:0] a_ff, a_in;
   logic [IW-1:0] b_ff, b_in;
   logic [IW-1:0] x_ff, x_in;
   logic [IW-1:0] p_ff, p_in;
   logic [IW-1:0] ra_ff, ra_in;
   logic [IW-1:0] root_ff, root_in;
   logic [RW-1:0] ka_ff, ka_in;
   logic [RW-1:0] kb_ff, kb_in;
   logic          phase_ff, phase_in;
   logic          same_ff, same_in;
   logic          merged_ff, merged_in;
   logic          err_ff, err_in;

   // ---- response output register ----
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_status_ff, rsp_status_in;
   logic [IW-1:0] rsp_root_ff, rsp_root_in;
   logic          rsp_same_ff, rsp_same_in;
   logic          rsp_merged_ff, rsp_merged_in;
   logic [CW-1:0] rsp_live_ff, rsp_live_in;

   // ---- table ports ----
   logic          par_we;
   logic [IW-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
   logic          rank_we;
   logic [IW-1:0] rank_waddr, rank_raddr;
   logic [RW-1:0] rank_wdata, rank_rdata;

   logic req_accept;
   logic rsp_accept;
   logic op_is_find;
   logic bad_index;
   logic rank_tie;

   dse_ram #(.WIDTH(IW), .DEPTH(dse_pkg::NODES)) u_parent (
      .clock         (clock),
      .write_enable  (par_we),
      .write_address (par_waddr),
      .write_data    (par_wdata),
      .read_address  (par_raddr),
      .read_data     (par_rdata)
   );

   dse_ram #(.WIDTH(RW), .DEPTH(dse_pkg::NODES)) u_rank (
      .clock         (clock),
      .write_enable  (rank_we),
      .write_address (rank_waddr),
      .write_data    (rank_wdata),
      .read_address  (rank_raddr),
      .read_data     (rank_rdata)
   );

   // ---- handshakes ----
   assign req_if.ready = (upc_ff == dse_pkg::ST_IDLE) && !clr_busy_ff;
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_accept   = rsp_valid_ff && rsp_if.ready;

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.root      = rsp_root_ff;
   assign rsp_if.same_set  = rsp_same_ff;
   assign rsp_if.merged    = rsp_merged_ff;
   assign rsp_if.live_sets = rsp_live_ff;

   // spare opcode behaves as find
   assign op_is_find = (op_ff != dse_pkg::OP_UNION) && (op_ff != dse_pkg::OP_CONNECTED);
   // second index only checked when it is used
   assign bad_index  = ({1'b0, a_ff} >= ecount_ff) ||
                       (!op_is_find && ({1'b0, b_ff} >= ecount_ff));
   assign rank_tie   = (ka_ff == kb_ff) && (ka_ff != dse_pkg::RANK_MAX);

   // ---- microprogram fetch and branch ----
   assign ctrl = dse_pkg::uc_rom(upc_ff);

   always_comb begin
      unique case (ctrl.cond)
         dse_pkg::C_NEVER:  cond_true = 1'b0;
         dse_pkg::C_ALWAYS: cond_true = 1'b1;
         dse_pkg::C_NO_REQ: cond_true = !req_accept;
         dse_pkg::C_BAD:    cond_true = bad_index;
         dse_pkg::C_ROOT:   cond_true = (par_rdata == x_ff);
         dse_pkg::C_SECOND: cond_true = phase_ff;
         dse_pkg::C_FIND:   cond_true = op_is_find;
         dse_pkg::C_SAME:   cond_true = (ra_ff == x_ff);
         dse_pkg::C_CONN:   cond_true = (op_ff == dse_pkg::OP_CONNECTED);
         dse_pkg::C_LT:     cond_true = (ka_ff < kb_ff);
         dse_pkg::C_BUSY:   cond_true = rsp_valid_ff && !rsp_if.ready;
         default:           cond_true = 1'b0;
      endcase
      if (cond_true) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = dse_pkg::step_type'(upc_ff + 5'd1);
      end
   end

   // ---- table addressing ----
   always_comb begin
      unique case (ctrl.prd_sel)
         dse_pkg::PR_X:  par_raddr = x_ff;
         dse_pkg::PR_A:  par_raddr = a_ff;
         dse_pkg::PR_P:  par_raddr = p_ff;
         dse_pkg::PR_RD: par_raddr = par_rdata;  // grandparent fetch
         default:        par_raddr = x_ff;
      endcase
      rank_raddr = (ctrl.krd_sel == dse_pkg::KR_X) ? x_ff : ra_ff;

      // clearing pass owns the write ports
      par_we    = 1'b0;
      par_waddr = x_ff;
      par_wdata = par_rdata;
      if (clr_busy_ff) begin
         par_we    = 1'b1;
         par_waddr = clr_idx_ff;
         par_wdata = clr_idx_ff;
      end else begin
         unique case (ctrl.pwr)
            dse_pkg::PW_NONE:  par_we = 1'b0;
            dse_pkg::PW_HALVE: begin
               par_we = 1'b1; par_waddr = x_ff; par_wdata = par_rdata;
            end
            dse_pkg::PW_GE: begin
               par_we = 1'b1; par_waddr = x_ff; par_wdata = ra_ff;
            end
            dse_pkg::PW_LT: begin
               par_we = 1'b1; par_waddr = ra_ff; par_wdata = x_ff;
            end
            default: par_we = 1'b0;
         endcase
      end

      if (clr_busy_ff) begin
         rank_we    = 1'b1;
         rank_waddr = clr_idx_ff;
         rank_wdata = '0;
      end else begin
         rank_we    = ctrl.rank_bump && rank_tie;
         rank_waddr = ra_ff;
         rank_wdata = RW'(ka_ff + 1'b1);
      end
   end

   // ---- next state ----
   always_comb begin
      // clamp element count to 1..NODES
      if (csr_write_data == '0) begin
         csr_clamped = CW'(1);
      end else if (csr_write_data > dse_pkg::NODES_CNT) begin
         csr_clamped = dse_pkg::NODES_CNT;
      end else begin
         csr_clamped = csr_write_data;
      end

      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      ecount_in   = ecount_ff;
      sets_in     = sets_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == dse_pkg::LAST_IDX) begin
            clr_busy_in = 1'b0;
         end
      end
      if (ctrl.merge && (sets_ff != '0)) begin
         sets_in = sets_ff - 1'b1;
      end
      if (csr_write_enable) begin
         clr_busy_in = 1'b1;
         clr_idx_in  = '0;
         ecount_in   = csr_clamped;
         sets_in     = csr_clamped;
      end

      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      phase_in  = phase_ff;
      same_in   = same_ff;
      merged_in = merged_ff;
      err_in    = err_ff;
      root_in   = root_ff;
      if (req_accept) begin
         op_in     = req_if.operation;
         a_in      = req_if.first_index;
         b_in      = req_if.second_index;
         phase_in  = 1'b0;
         same_in   = 1'b0;
         merged_in = 1'b0;
         err_in    = dse_pkg::STATUS_OK;
         root_in   = '0;
      end
      if (ctrl.set_phase) phase_in  = 1'b1;
      if (ctrl.set_same)  same_in   = 1'b1;
      if (ctrl.merge)     merged_in = 1'b1;
      if (ctrl.set_err)   err_in    = dse_pkg::STATUS_BAD_INDEX;
      if (ctrl.ld_root)   root_in   = x_ff;

      unique case (ctrl.xld)
         dse_pkg::XL_HOLD: x_in = x_ff;
         dse_pkg::XL_A:    x_in = a_ff;
         dse_pkg::XL_B:    x_in = b_ff;
         dse_pkg::XL_P:    x_in = p_ff;
         default:          x_in = x_ff;
      endcase
      p_in  = ctrl.ld_p  ? par_rdata  : p_ff;
      ra_in = ctrl.ld_ra ? x_ff       : ra_ff;
      ka_in = ctrl.ld_ka ? rank_rdata : ka_ff;
      kb_in = ctrl.ld_kb ? rank_rdata : kb_ff;

      // response slot: freed by a taken beat, filled at the emit step
      rsp_valid_in  = rsp_valid_ff && !rsp_accept;
      rsp_status_in = rsp_status_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_same_in   = rsp_same_ff;
      rsp_merged_in = rsp_merged_ff;
      rsp_live_in   = rsp_live_ff;
      if (ctrl.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = err_ff;
         rsp_root_in   = root_ff;
         rsp_same_in   = same_ff;
         rsp_merged_in = merged_ff;
         rsp_live_in   = sets_ff;
      end
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= dse_pkg::ST_IDLE;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         ecount_ff    <= dse_pkg::NODES_CNT;
         sets_ff      <= dse_pkg::NODES_CNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         clr_busy_ff  <= clr_busy_in;
         clr_idx_ff   <= clr_idx_in;
         ecount_ff    <= ecount_in;
         sets_ff      <= sets_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- datapath and payload registers ----
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      x_ff          <= x_in;
      p_ff          <= p_in;
      ra_ff         <= ra_in;
      root_ff       <= root_in;
      ka_ff         <= ka_in;
      kb_ff         <= kb_in;
      phase_ff      <= phase_in;
      same_ff       <= same_in;
      merged_ff     <= merged_in;
      err_ff        <= err_in;
      rsp_status_ff <= rsp_status_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_same_ff   <= rsp_same_in;
      rsp_merged_ff <= rsp_merged_in;
      rsp_live_ff   <= rsp_live_in;
   end

endmodule

// ===== src/dse_ram.sv =====
// dse_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module dse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data <= mem[read_address];
   end

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for disjoint_set_engine (union-find forest).
// Depends on dse_pkg, dse_req_if, dse_rsp_if and the engine RTL in src/.
`timescale 1ns / 100ps

module testbench;

   // spare selector, treated by the engine as find
   localparam logic [1:0] OP_SPARE = 2'd3;
   // cycles with no beat on either channel before the run is abandoned
   localparam int STALL_LIMIT = 20000;
   // cycles per idling period, and the stretch of it where no idling happens
   localparam int IDLE_PERIOD = 4000;
   localparam int QUIET_SPAN  = 500;
   // the one long receiver hold-off
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      logic [1:0]                operation;
      logic [dse_pkg::IDX_W-1:0] first_index;
      logic [dse_pkg::IDX_W-1:0] second_index;
   } dsu_request_type;

   typedef struct packed {
      logic                        status;
      logic [dse_pkg::IDX_W-1:0]   root;
      logic                        same_set;
      logic                        merged;
      logic [dse_pkg::COUNT_W-1:0] live_sets;
   } dsu_result_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_write_enable;
   logic [dse_pkg::COUNT_W-1:0] csr_write_data;

   dse_req_if req_if ();
   dse_rsp_if rsp_if ();

   disjoint_set_engine uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------
   // Shadow forest: our own copy of the parent/rank tables, the live set
   // count and the element count. Updated at each accepted request beat.
   // ---------------------------------------------------------------------
   logic [dse_pkg::IDX_W-1:0]   forest_parent [dse_pkg::NODES];
   logic [dse_pkg::RANK_W-1:0]  forest_rank   [dse_pkg::NODES];
   logic [dse_pkg::COUNT_W-1:0] model_sets;
   logic [dse_pkg::COUNT_W-1:0] model_count;

   dsu_request_type queued_requests[$];   // waiting to be driven
   dsu_result_type  predicted_replies[$]; // one per accepted request, in order

   int fault_count     = 0;
   int cycle_no        = 0;
   int stall_cycles    = 0;
   int replies_seen    = 0;
   int hold_left       = 0;
   bit hold_done       = 1'b0;
   int deepest_walk    = 0;
   int bad_seen        = 0;
   int merges_seen     = 0;
   int count_writes    = 0;
   int op_tally [4]    = '{0, 0, 0, 0};
   dsu_request_type beat;

   // clamp like the engine does: 0 -> 1, above NODES -> NODES
   function automatic void reinit_forest(input logic [dse_pkg::COUNT_W-1:0] value);
      logic [dse_pkg::COUNT_W-1:0] n;
      n = value;
      if (n < 1) n = 1;
      if (n > dse_pkg::NODES_CNT) n = dse_pkg::NODES_CNT;
      model_count = n;
      model_sets  = n;
      for (int i = 0; i < dse_pkg::NODES; i++) begin
         forest_parent[i] = dse_pkg::IDX_W'(i);
         forest_rank[i]   = '0;
      end
   endfunction

   // walk to the root, repointing each visited node to its grandparent
   function automatic logic [dse_pkg::IDX_W-1:0] walk_to_root(
         input logic [dse_pkg::IDX_W-1:0] start);
      logic [dse_pkg::IDX_W-1:0] x;
      logic [dse_pkg::IDX_W-1:0] up;
      int hops;
      x = start;
      hops = 0;
      while (forest_parent[x] != x && hops < dse_pkg::NODES) begin
         up = forest_parent[x];
         forest_parent[x] = forest_parent[up];
         x = up;
         hops++;
      end
      if (hops > deepest_walk) deepest_walk = hops;
      return x;
   endfunction

   function automatic dsu_result_type apply_request(input dsu_request_type r);
      dsu_result_type res;
      logic [1:0] op;
      logic [dse_pkg::IDX_W-1:0] ra;
      logic [dse_pkg::IDX_W-1:0] rb;
      res = '0;
      op_tally[r.operation]++;
      op = (r.operation == OP_SPARE) ? dse_pkg::OP_FIND : r.operation;
      if (r.first_index >= model_count ||
          (op != dse_pkg::OP_FIND && r.second_index >= model_count)) begin
         // out of range: nothing moves, root reads 0
         res.status = dse_pkg::STATUS_BAD_INDEX;
         bad_seen++;
      end else if (op == dse_pkg::OP_FIND) begin
         res.status = dse_pkg::STATUS_OK;
         res.root   = walk_to_root(r.first_index);
      end else begin
         res.status = dse_pkg::STATUS_OK;
         ra = walk_to_root(r.first_index);
         rb = walk_to_root(r.second_index);
         res.root = ra;
         if (ra == rb) begin
            res.same_set = 1'b1;
         end else if (op == dse_pkg::OP_UNION) begin
            if (forest_rank[ra] < forest_rank[rb]) begin
               forest_parent[ra] = rb;
               res.root = rb;
            end else begin
               // second root goes under the first; first rank rises on a tie below max
               forest_parent[rb] = ra;
               if (forest_rank[ra] == forest_rank[rb] &&
                   forest_rank[ra] < dse_pkg::RANK_MAX)
                  forest_rank[ra] = forest_rank[ra] + 1'b1;
            end
            res.merged = 1'b1;
            if (model_sets != 0) model_sets = model_sets - 1'b1;
            merges_seen++;
         end
      end
      res.live_sets = model_sets;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // any beat on either channel resets the stall count; the clearing pass
   // and the long hold-off stay well under the limit
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d replies pending",
                  STALL_LIMIT, predicted_replies.size());
         $display("testbench: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request driver. Prediction happens at the accepting edge, so the
   // shadow forest advances in exactly the order the engine sees requests.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid        <= 1'b0;
         req_if.operation    <= dse_pkg::OP_FIND;
         req_if.first_index  <= '0;
         req_if.second_index <= '0;
      end else begin
         if (req_if.valid && req_if.ready)
            predicted_replies.push_back(apply_request({req_if.operation,
                                                       req_if.first_index,
                                                       req_if.second_index}));
         // slot is free when nothing is offered or the offer just went in
         if (!req_if.valid || req_if.ready) begin
            if (queued_requests.size() != 0 &&
                ((cycle_no % IDLE_PERIOD) < QUIET_SPAN || $urandom_range(99) >= 37)) begin
               beat = queued_requests.pop_front();
               req_if.operation    <= beat.operation;
               req_if.first_index  <= beat.first_index;
               req_if.second_index <= beat.second_index;
               req_if.valid        <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Reply monitor and receiver ready. Once, after HOLD_AT replies, ready
   // is held low long enough for the engine to back up into the request
   // side while the driver keeps offering.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      dsu_result_type got;
      dsu_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.status, rsp_if.root, rsp_if.same_set, rsp_if.merged,
                   rsp_if.live_sets};
            if (predicted_replies.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: reply beat with nothing expected: %p", $realtime, got);
            end else begin
               want = predicted_replies.pop_front();
               if (got.status !== want.status || got.root !== want.root ||
                   got.same_set !== want.same_set || got.merged !== want.merged ||
                   got.live_sets !== want.live_sets) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("%0t: reply %0d mismatch: expected %p, got %p",
                              $realtime, replies_seen, want, got);
               end
            end
            replies_seen++;
            if (replies_seen == HOLD_AT && !hold_done) begin
               hold_left = HOLD_CYCLES;
               hold_done = 1'b1;
            end
         end
         if (hold_left != 0) hold_left--;
         rsp_if.ready <= (hold_left == 0) &&
                         (((cycle_no + IDLE_PERIOD / 2) % IDLE_PERIOD) < QUIET_SPAN ||
                          $urandom_range(99) >= 37);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic push_request(input logic [1:0] op, input int a, input int b);
      dsu_request_type r;
      r.operation    = op;
      r.first_index  = dse_pkg::IDX_W'(a);
      r.second_index = dse_pkg::IDX_W'(b);
      queued_requests.push_back(r);
   endtask

   // Mostly well-formed traffic over a narrow window so unions pile up into
   // deep trees; the rest covers the full index range and bad indices.
   task automatic queue_random(input int n);
      dsu_request_type r;
      int unsigned roll;
      int unsigned window;
      repeat (n) begin
         roll   = $urandom_range(99);
         window = (model_count > 48 && $urandom_range(9) < 7) ? 48 : model_count;
         r.first_index  = dse_pkg::IDX_W'($urandom_range(window - 1));
         r.second_index = dse_pkg::IDX_W'($urandom_range(window - 1));
         if (roll < 45) begin
            r.operation = dse_pkg::OP_UNION;
         end else if (roll < 70) begin
            r.operation    = dse_pkg::OP_FIND;
            r.second_index = dse_pkg::IDX_W'($urandom);   // don't-care for find
         end else if (roll < 88) begin
            r.operation = dse_pkg::OP_CONNECTED;
         end else if (roll < 92) begin
            r.operation    = OP_SPARE;
            r.second_index = dse_pkg::IDX_W'($urandom);
         end else begin
            r.operation = 2'($urandom_range(3));
            if (model_count < dse_pkg::NODES_CNT) begin
               if ($urandom_range(1))
                  r.first_index  = dse_pkg::IDX_W'($urandom_range(dse_pkg::NODES - 1,
                                                                  model_count));
               else
                  r.second_index = dse_pkg::IDX_W'($urandom_range(dse_pkg::NODES - 1,
                                                                  model_count));
            end
         end
         queued_requests.push_back(r);
      end
   endtask

   // engine is idle once every request went in and every reply came out
   task automatic drain;
      while (queued_requests.size() != 0 || req_if.valid || predicted_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_element_count(input logic [dse_pkg::COUNT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      reinit_forest(value);
      count_writes++;
   endtask

   task automatic run_phase(input logic [dse_pkg::COUNT_W-1:0] value, input int n);
      write_element_count(value);
      queue_random(n);
      drain();
   endtask

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      reinit_forest(dse_pkg::NODES_CNT);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, full forest after reset (clearing pass holds off ready)
      push_request(dse_pkg::OP_FIND,      0,    0);
      push_request(dse_pkg::OP_FIND,      1023, 1023);
      push_request(dse_pkg::OP_CONNECTED, 0,    1023);    // different sets
      push_request(dse_pkg::OP_UNION,     0,    1023);    // rank tie, 1023 under 0
      push_request(dse_pkg::OP_UNION,     1023, 0);       // already joined
      push_request(dse_pkg::OP_CONNECTED, 1023, 0);
      push_request(OP_SPARE,              1023, 0);       // spare selector acts as find
      push_request(dse_pkg::OP_UNION,     1,    2);
      push_request(dse_pkg::OP_UNION,     2,    0);       // tie of rank-1 roots
      push_request(dse_pkg::OP_UNION,     3,    1);       // lower rank first: root moves
      push_request(dse_pkg::OP_UNION,     1,    4);       // higher rank first
      push_request(dse_pkg::OP_FIND,      1023, 0);       // two-hop walk, halved
      push_request(dse_pkg::OP_CONNECTED, 512,  511);
      push_request(dse_pkg::OP_FIND,      682,  341);     // alternating bit patterns
      queue_random(130);
      drain();

      // small forest: bad indices on either side, ignored second on find
      write_element_count(11'd16);
      push_request(dse_pkg::OP_FIND,      16,   0);
      push_request(dse_pkg::OP_FIND,      1023, 0);
      push_request(dse_pkg::OP_UNION,     0,    16);
      push_request(dse_pkg::OP_CONNECTED, 15,   1023);
      push_request(dse_pkg::OP_FIND,      15,   1023);
      push_request(OP_SPARE,              3,    1023);
      push_request(dse_pkg::OP_UNION,     15,   0);
      queue_random(100);
      drain();

      run_phase(11'd0,    40);    // taken as one element
      run_phase(11'd2047, 260);   // clamped to the full forest
      run_phase(11'd2,    40);
      run_phase(11'd40,   150);
      run_phase(11'd1024, 150);
      run_phase(11'd7,    60);
      run_phase(11'd300,  80);

      // tail: catch any stray reply beat
      repeat (100) @(posedge clock);
      fault_count += predicted_replies.size();

      $display("covered %0d finds, %0d unions, %0d connected, %0d spare; %0d bad index",
               op_tally[dse_pkg::OP_FIND], op_tally[dse_pkg::OP_UNION],
               op_tally[dse_pkg::OP_CONNECTED], op_tally[OP_SPARE], bad_seen);
      $display("%0d merges, deepest walk %0d hops, %0d count writes, %0d reply faults",
               merges_seen, deepest_walk, count_writes, fault_count);
      if (fault_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
